@@ rtl/ritoa_pkg.sv @@
// Shared types, constants and the sequencer program of the radix integer-to-ASCII converter.
package ritoa_pkg;

   localparam int VALUE_W   = 32;
   localparam int MODE_W    = 2;
   localparam int CNT_W     = 6;
   localparam int IDX_W     = 5;
   localparam int CHAR_W    = 7;
   localparam int DIGIT_W   = 4;
   localparam int DIGIT_CAP = 32;
   localparam int DEC_SHIFT = 35;
   localparam int QDEC_W    = 2 * VALUE_W - DEC_SHIFT;

   localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;

   localparam logic [MODE_W-1:0] MODE_BIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEC = 2'd1;

   typedef logic [1:0] step_type;

   localparam step_type STEP_IDLE = 2'd0;
   localparam step_type STEP_MUL  = 2'd1;
   localparam step_type STEP_DIV  = 2'd2;
   localparam step_type STEP_EMIT = 2'd3;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_MORE,
      COND_EMIT_PENDING
   } cond_type;

   typedef struct packed {
      logic     load;
      logic     mul;
      logic     div;
      logic     emit;
      cond_type cond;
      step_type target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic more;
      logic emit_done;
   } flags_type;

   function automatic ctl_type rom_word(step_type step);
      ctl_type w;
      w = '{load: 1'b0, mul: 1'b0, div: 1'b0, emit: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.load = 1'b1; w.cond = COND_NO_REQ; w.target = STEP_IDLE;
         end
         STEP_MUL: begin
            w.mul = 1'b1; w.cond = COND_NEVER; w.target = STEP_IDLE;
         end
         STEP_DIV: begin
            w.div = 1'b1; w.cond = COND_MORE; w.target = STEP_MUL;
         end
         STEP_EMIT: begin
            w.emit = 1'b1; w.cond = COND_EMIT_PENDING; w.target = STEP_EMIT;
         end
         default: begin
            w.cond = COND_NEVER;
         end
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = 7'd48 + {3'd0, d};
      end else begin
         c = 7'd55 + {3'd0, d};
      end
      return c;
   endfunction

endpackage

@@ rtl/ritoa_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
interface ritoa_req_if;
   logic                              valid;
   logic                              ready;
   logic [ritoa_pkg::VALUE_W-1:0]     value;
   logic [ritoa_pkg::MODE_W-1:0]      mode;
   logic [ritoa_pkg::CNT_W-1:0]       max_digits;

   modport source (output valid, value, mode, max_digits, input ready);
   modport sink   (input valid, value, mode, max_digits, output ready);
endinterface

interface ritoa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ritoa_pkg::CHAR_W-1:0]      ascii_char;
   logic                              last;

   modport source (output valid, ascii_char, last, input ready);
   modport sink   (input valid, ascii_char, last, output ready);
endinterface

@@ rtl/radix_integer_to_ascii.sv @@
// Top level: radix integer-to-ASCII converter with digit store and output register.
//
// Usage: a request beat on req_if carries a 32-bit unsigned value, a radix mode
// (0 binary, 1 decimal, 2 or 3 upper-case hex) and a digit limit (0 acts as 1,
// above 32 acts as 32). The block answers with one rsp_if beat per ASCII digit,
// most significant first, no leading zeros, at least one digit; when the value
// has more digits than the limit, only the least significant ones are sent.
// The final digit beat has last set.
// Timing: each digit costs a multiply step and a divide step of the
// sequencer (the decimal quotient comes from a registered reciprocal
// multiply), then digits leave one per cycle from the output register
// while the receiver is ready.
// A new request is taken once the sequencer is back at its idle step, even
// while the final digit still waits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp valid. A stalled receiver holds the output register and the sequencer
// waits in its emit step; nothing is lost.
module radix_integer_to_ascii (
   input logic        clock,
   input logic        reset,
   ritoa_req_if.sink   req_if,
   ritoa_rsp_if.source rsp_if
);

   ritoa_pkg::ctl_type   ctl;
   ritoa_pkg::flags_type flags;
   ritoa_pkg::step_type  step;

   logic [ritoa_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic [ritoa_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [ritoa_pkg::CNT_W-1:0]     limit_ff, limit_in;
   logic [ritoa_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ritoa_pkg::QDEC_W-1:0]    qdec_ff, qdec_in;
   logic [ritoa_pkg::IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                            out_valid_ff, out_valid_in;
   logic [ritoa_pkg::CHAR_W-1:0]    out_char_ff;
   logic                            out_last_ff;
   logic [ritoa_pkg::DIGIT_W-1:0]   store [ritoa_pkg::DIGIT_CAP];

   logic                            accept;
   logic                            emit_go;
   logic [2*ritoa_pkg::VALUE_W-1:0] prod;
   logic [ritoa_pkg::VALUE_W-1:0]   quot;
   logic [ritoa_pkg::DIGIT_W-1:0]   rem;
   logic [ritoa_pkg::DIGIT_W-1:0]   q10_lo;
   logic [ritoa_pkg::CNT_W-1:0]     cnt_next;
   logic [ritoa_pkg::CNT_W-1:0]     lim_sat;

   ritoa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .step  (step)
   );

   assign req_if.ready      = ctl.load;
   assign accept            = req_if.valid && ctl.load;
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.ascii_char = out_char_ff;
   assign rsp_if.last       = out_last_ff;

   assign emit_go  = ctl.emit && (!out_valid_ff || rsp_if.ready);
   assign prod     = val_ff * ritoa_pkg::DEC_RECIP;
   assign cnt_next = cnt_ff + 6'd1;

   always_comb begin
      if (req_if.max_digits == '0) begin
         lim_sat = 6'd1;
      end else if (req_if.max_digits > 6'(ritoa_pkg::DIGIT_CAP)) begin
         lim_sat = 6'(ritoa_pkg::DIGIT_CAP);
      end else begin
         lim_sat = req_if.max_digits;
      end
   end

   always_comb begin
      q10_lo = '0;
      case (mode_ff)
         ritoa_pkg::MODE_BIN: begin
            quot = {1'b0, val_ff[ritoa_pkg::VALUE_W-1:1]};
            rem  = {3'd0, val_ff[0]};
         end
         ritoa_pkg::MODE_DEC: begin
            quot   = {3'd0, qdec_ff};
            q10_lo = {qdec_ff[2:0], 1'b0} + {qdec_ff[0], 3'd0};
            rem    = val_ff[3:0] - q10_lo;
         end
         default: begin
            quot = {4'd0, val_ff[ritoa_pkg::VALUE_W-1:4]};
            rem  = val_ff[3:0];
         end
      endcase
   end

   assign flags.req_valid = req_if.valid;
   assign flags.more      = (quot != '0) && (cnt_next < limit_ff);
   assign flags.emit_done = emit_go && (rd_idx_ff == '0);

   always_comb begin
      val_in    = val_ff;
      mode_in   = mode_ff;
      limit_in  = limit_ff;
      cnt_in    = cnt_ff;
      qdec_in   = qdec_ff;
      rd_idx_in = rd_idx_ff;
      if (accept) begin
         val_in   = req_if.value;
         mode_in  = req_if.mode;
         limit_in = lim_sat;
         cnt_in   = '0;
      end
      if (ctl.mul) begin
         qdec_in = prod[2*ritoa_pkg::VALUE_W-1:ritoa_pkg::DEC_SHIFT];
      end
      if (ctl.div) begin
         val_in    = quot;
         cnt_in    = cnt_next;
         rd_idx_in = cnt_ff[ritoa_pkg::IDX_W-1:0];
      end
      if (emit_go) begin
         rd_idx_in = rd_idx_ff - 5'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      mode_ff   <= mode_in;
      limit_ff  <= limit_in;
      qdec_ff   <= qdec_in;
      rd_idx_ff <= rd_idx_in;
   end

   // digit store: written by the divide step, read into the output register
   always_ff @(posedge clock) begin
      if (ctl.div) begin
         store[cnt_ff[ritoa_pkg::IDX_W-1:0]] <= rem;
      end
      if (emit_go) begin
         out_char_ff <= ritoa_pkg::glyph(store[rd_idx_ff]);
         out_last_ff <= (rd_idx_ff == '0);
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step == ritoa_pkg::STEP_MUL) && (cnt_ff == '0))
      else $error("accepted request did not start a conversion");

   a_dec_digit: assert property (@(posedge clock) disable iff (reset)
      (ctl.div && mode_ff == ritoa_pkg::MODE_DEC) |-> (rem < 4'd10))
      else $error("decimal remainder out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (step == ritoa_pkg::STEP_EMIT) |-> (cnt_ff != '0) && (cnt_ff <= limit_ff))
      else $error("digit count outside limit during emit");

   a_read_idx: assert property (@(posedge clock) disable iff (reset)
      (step == ritoa_pkg::STEP_EMIT) |-> ({1'b0, rd_idx_ff} < cnt_ff))
      else $error("read index beyond produced digits");

endmodule

@@ rtl/ritoa_seq.sv @@
// Microcode sequencer: step counter, program ROM and conditional jumps.
module ritoa_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  ritoa_pkg::flags_type  flags,
   output ritoa_pkg::ctl_type    ctl,
   output ritoa_pkg::step_type   step
);

   ritoa_pkg::step_type step_ff;
   ritoa_pkg::step_type step_in;
   logic                taken;

   assign ctl  = ritoa_pkg::rom_word(step_ff);
   assign step = step_ff;

   always_comb begin
      case (ctl.cond)
         ritoa_pkg::COND_NEVER:        taken = 1'b0;
         ritoa_pkg::COND_NO_REQ:       taken = !flags.req_valid;
         ritoa_pkg::COND_MORE:         taken = flags.more;
         ritoa_pkg::COND_EMIT_PENDING: taken = !flags.emit_done;
         default:                      taken = 1'b0;
      endcase
   end

   always_comb begin
      step_in = taken ? ctl.target : step_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ritoa_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
